// ===== rtl/core/bdb_pkg.sv =====
// Shared types and constants for the bounded deque and bag.
`timescale 1ns / 1ps

package bdb_pkg;

    // Widths of the request and result fields.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the incoming request
        logic exec;      // apply push or pop, set up a scan
        logic scan;      // one step of the search walk
        logic shift;     // one step of the removal shift
        logic rd_front;  // read the front entry
        logic rd_back;   // read the back entry, keep the front
        logic out_load;  // load the result register
    } dp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_go;    // search command on a non-empty store
        logic is_remove;  // latched command is a removal
        logic hit;        // compared entry matches the value
        logic miss;       // last live entry compared without a match
        logic shift_done; // removal shift has finished
        logic out_busy;   // result register still waits to be taken
    } dp_stat_t;

endpackage

// ===== rtl/core/bdb_ctrl.sv =====
// Controller state machine for the bounded deque and bag.
`timescale 1ns / 1ps

module bdb_ctrl
    import bdb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t sts,
    output dp_ctrl_t ctl
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EXEC     = 7'b0000010,
        ST_SCAN     = 7'b0000100,
        ST_SHIFT    = 7'b0001000,
        ST_RD_FRONT = 7'b0010000,
        ST_RD_BACK  = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.scan_go)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = sts.is_remove ? ST_SHIFT : ST_RD_FRONT;
                end
                else if (sts.miss)
                begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_RD_FRONT:
            begin
                ctl.rd_front = 1'b1;
                state_next   = ST_RD_BACK;
            end
            ST_RD_BACK:
            begin
                ctl.rd_back = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/bdb_datapath.sv =====
// Datapath for the bounded deque and bag: ring store, pointers and result register.
`timescale 1ns / 1ps

module bdb_datapath
    import bdb_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_ctrl_t            ctl,
    output dp_stat_t            sts,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [FIELD_W-1:0]  s_value,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,
    output logic [2:0]          m_tuser
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    // Ring slot of a position counted from the front.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [CMD_W-1:0]       cmd_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          walk_idx_reg, walk_idx_next;
    logic                   pipe_valid_reg, pipe_valid_next;
    logic [CW-1:0]          pipe_idx_reg, pipe_idx_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   found_reg, found_next;
    logic [VALUE_WIDTH-1:0] front_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;

    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     out_front_reg;
    logic [FIELD_W-1:0]     out_back_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_empty_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic                   out_found_reg;

    logic                   is_push, is_search, is_remove;
    logic                   full, empty, walk_live, match;
    logic [CW-1:0]          count_m1;
    logic [AW-1:0]          head_dec, head_inc;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [CW-1:0]          rd_pos;
    logic [AW-1:0]          rd_addr;

    assign is_push   = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK);
    assign is_remove = (cmd_reg == CMD_REMOVE);
    assign is_search = (cmd_reg == CMD_CONTAINS) || is_remove;
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign count_m1  = count_reg - CW'(1);
    assign walk_live = (walk_idx_reg < count_reg);
    assign match     = (rdata_reg == value_reg);
    assign head_dec  = (head_reg == '0) ? LAST_C : head_reg - AW'(1);
    assign head_inc  = (head_reg == LAST_C) ? '0 : head_reg + AW'(1);

    assign sts.scan_go    = is_search && !empty;
    assign sts.is_remove  = is_remove;
    assign sts.hit        = pipe_valid_reg && match;
    assign sts.miss       = pipe_valid_reg && !match && (pipe_idx_reg == count_m1);
    assign sts.shift_done = !walk_live && !pipe_valid_reg;
    assign sts.out_busy   = out_valid_reg && !m_tready;

    // Pointer, count and walk control.
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        walk_idx_next   = walk_idx_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_idx_next   = pipe_idx_reg;
        status_next     = status_reg;
        found_next      = found_reg;

        if (ctl.exec)
        begin
            walk_idx_next   = '0;
            pipe_valid_next = 1'b0;
            status_next     = STATUS_DONE;
            found_next      = 1'b0;
            case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        head_next  = head_inc;
                        count_next = count_m1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_m1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.scan)
        begin
            if (sts.hit)
            begin
                found_next      = 1'b1;
                // Start the shift just past the matching entry.
                walk_idx_next   = pipe_idx_reg + CW'(1);
                pipe_valid_next = 1'b0;
            end
            else
            begin
                if (sts.miss && is_remove)
                begin
                    status_next = STATUS_NOT_FOUND;
                end
                pipe_valid_next = walk_live;
                pipe_idx_next   = walk_idx_reg;
                if (walk_live)
                begin
                    walk_idx_next = walk_idx_reg + CW'(1);
                end
            end
        end

        if (ctl.shift)
        begin
            // Entry read now lands one place toward the front next cycle.
            pipe_valid_next = walk_live;
            pipe_idx_next   = walk_idx_reg - CW'(1);
            if (walk_live)
            begin
                walk_idx_next = walk_idx_reg + CW'(1);
            end
            if (sts.shift_done)
            begin
                count_next = count_m1;
            end
        end
    end

    // Memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, pipe_idx_reg);
        wr_data = rdata_reg;
        if (ctl.exec && is_push && !full)
        begin
            wr_en   = 1'b1;
            wr_data = value_reg;
            wr_addr = (cmd_reg == CMD_PUSH_FRONT) ? head_dec : slot_of(head_reg, count_reg);
        end
        else if (ctl.shift && pipe_valid_reg)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_en   = ((ctl.scan || ctl.shift) && walk_live) || ctl.rd_front || ctl.rd_back;
    assign rd_pos  = ctl.rd_back ? count_m1 : (ctl.rd_front ? '0 : walk_idx_reg);
    assign rd_addr = slot_of(head_reg, rd_pos);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            pipe_valid_reg <= pipe_valid_next;
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg <= walk_idx_next;
        pipe_idx_reg <= pipe_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        if (ctl.load)
        begin
            cmd_reg   <= s_cmd;
            value_reg <= VALUE_WIDTH'(s_value);
        end
        if (ctl.rd_back)
        begin
            front_reg <= rdata_reg;
        end
        if (ctl.out_load)
        begin
            out_front_reg  <= empty ? '0 : FIELD_W'(front_reg);
            out_back_reg   <= empty ? '0 : FIELD_W'(rdata_reg);
            out_count_reg  <= COUNT_W'(count_reg);
            out_empty_reg  <= empty;
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_empty_reg, out_count_reg, out_back_reg, out_front_reg};
    assign m_tuser  = {out_found_reg, out_status_reg};

endmodule

// ===== rtl/core/bounded_deque_bag.sv =====
// Top level of the bounded double-ended queue with bag operations.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: value
// m_axis    out        tuser: status, found; tdata: front, back, count, empty
//
// Sequence: a push, a pop or an unused command passes through the execute, read
// front, read back and output states before its result is offered, and the
// next request is taken once the controller is back in idle. Contains and
// remove walk the ring through the single read port of the entry store, one
// entry a cycle. A removal then moves each later entry one slot toward the
// front at one entry a cycle. The slowest request is a removal of an early
// entry from a full store.
// Reset clears the front index, the entry count, the walk valid flag and the output
// valid flag; the entry store itself is not cleared, and front and back are zero in an empty result.
// The result register holds a finished result while the next request is
// accepted and worked on; only the final load waits for m_axis_tready.

module bounded_deque_bag
    import bdb_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] front_value, [63:32] back_value,
                                        // [70:64] entry_count, [71] is_empty
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] found
);

    dp_ctrl_t ctl;
    dp_stat_t sts;

    // The controller sequences each request; the datapath owns all storage.
    bdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    bdb_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .s_cmd    (s_axis_tuser),
        .s_value  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule

// ===== dv/bounded_deque_bag_sb_pkg.sv =====
// Shadow deque and result scoreboard for the bounded deque and bag testbench.
`timescale 1ns / 1ps

package bounded_deque_bag_sb_pkg;

    import bdb_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int MAX_REPORTS = 40;

    // One result as the block reports it, most significant field first.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [FIELD_W-1:0]  front_value;
        logic [FIELD_W-1:0]  back_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } deque_result_t;

    class deque_tracker;
        logic [FIELD_W-1:0] slots [RING_DEPTH];
        int                 head;
        int                 live;
        deque_result_t      due_results [$];
        int                 results_seen;
        int                 mismatches;

        function new();
            head         = 0;
            live         = 0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function int occupancy();
            return live;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int ring_slot(int pos);
            return (head + pos) % RING_DEPTH;
        endfunction

        function logic [FIELD_W-1:0] entry_at(int pos);
            return slots[ring_slot(pos)];
        endfunction

        // Position of the first live entry equal to the value, counted from
        // the front, or -1 when there is none.
        function int locate(logic [FIELD_W-1:0] value);
            for (int i = 0; i < live; i++)
            begin
                if (entry_at(i) == value)
                    return i;
            end
            return -1;
        endfunction

        // Applies one accepted request to the shadow deque and queues the
        // result the block must report for it.
        function void apply_request(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] value);
            deque_result_t res;
            int            pos;
            res = '0;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (live >= RING_DEPTH)
                        res.status = STATUS_FULL;
                    else
                    begin
                        if (cmd == CMD_PUSH_FRONT)
                        begin
                            head        = (head + RING_DEPTH - 1) % RING_DEPTH;
                            slots[head] = value;
                        end
                        else
                            slots[ring_slot(live)] = value;
                        live++;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (live == 0)
                        res.status = STATUS_EMPTY;
                    else
                    begin
                        if (cmd == CMD_POP_FRONT)
                            head = (head + 1) % RING_DEPTH;
                        live--;
                    end
                end
                CMD_CONTAINS:
                    res.found = (locate(value) >= 0);
                CMD_REMOVE:
                begin
                    pos = locate(value);
                    if (pos < 0)
                        res.status = STATUS_NOT_FOUND;
                    else
                    begin
                        res.found = 1'b1;
                        for (int i = pos; i + 1 < live; i++)
                            slots[ring_slot(i)] = entry_at(i + 1);
                        live--;
                    end
                end
                default:
                    ;
            endcase
            res.entry_count = COUNT_W'(live);
            res.is_empty    = (live == 0);
            if (live != 0)
            begin
                res.front_value = entry_at(0);
                res.back_value  = entry_at(live - 1);
            end
            due_results.push_back(res);
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH: %s", what);
        endtask

        task compare_field(string name, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
            if (got !== want)
                flag_mismatch($sformatf("result %0d %s: got %h, want %h",
                                        results_seen, name, got, want));
        endtask

        task check_result(deque_result_t got);
            deque_result_t want;
            results_seen++;
            if (due_results.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d arrived with no request outstanding",
                                        results_seen));
                return;
            end
            want = due_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("found", got.found, want.found);
            compare_field("front_value", got.front_value, want.front_value);
            compare_field("back_value", got.back_value, want.back_value);
            compare_field("entry_count", got.entry_count, want.entry_count);
            compare_field("is_empty", got.is_empty, want.is_empty);
        endtask
    endclass

endpackage

// ===== dv/bounded_deque_bag_tb.sv =====
// Self-checking testbench for the bounded deque and bag, driving random command traffic.
`timescale 1ns / 1ps

// Every accepted request is applied to a shadow deque held in a small scoreboard
// class, which queues the result the block owes for it. Each result taken from
// the master side is compared field by field with the oldest queued one.
//
// The run starts with a short directed pass over the empty-deque refusals, the unused
// command codes, value extremes and removals at the front, middle and back.
// Random traffic then follows in four handshake phases: no idling, sender idle
// most of the time, receiver stalling most of the time, and both idling a bit.
// Within each phase the traffic moves between filling the deque to the top,
// churning around the middle, and draining it to empty, so full and empty
// refusals, ring wrap and removal shifts across the wrap point all come up.
// Search values are often taken from the live entries so contains and remove
// hit as well as miss, and pushes draw from a small pool to create duplicates.
module bounded_deque_bag_tb;

    import bdb_pkg::*;
    import bounded_deque_bag_sb_pkg::*;

    localparam int DEPTH            = RING_DEPTH;
    localparam int REQUESTS_A_PHASE = 360;
    localparam int DRAIN_CYCLES     = 2 * DEPTH + 16;
    // Even the slowest request, with stalls on top, stays far below this limit.
    localparam int QUIET_LIMIT      = 4000;

    // Command codes the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Values pushed by the random traffic, chosen so duplicates are common.
    localparam logic [FIELD_W-1:0] VALUE_POOL [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
        32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678
    };

    typedef enum {FILL_UP, CHURN, EMPTY_OUT} traffic_mode_t;

    logic               clk;
    logic               rst_n          = 1'b0;
    logic               s_axis_tvalid  = 1'b0;
    logic [31:0]        s_axis_tdata   = '0;
    logic [2:0]         s_axis_tuser   = '0;
    logic               m_axis_tready  = 1'b0;
    logic               s_axis_tready;
    logic               m_axis_tvalid;
    logic [71:0]        m_axis_tdata;
    logic [2:0]         m_axis_tuser;

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 quiet_cycles   = 0;
    deque_tracker       sb;
    deque_result_t      seen_result;

    bounded_deque_bag #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (FIELD_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The result as the block packs it: status and found in tuser; front, back,
    // count and empty in tdata from the lowest bit up.
    assign seen_result = {m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata[31:0],
                          m_axis_tdata[63:32], m_axis_tdata[70:64], m_axis_tdata[71]};

    // Result side: everything is sampled as it stood just before the edge, then
    // tready for the next cycle is chosen by the current stall rate. The
    // watchdog ends the run when no request and no result has moved for a long
    // stretch.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(seen_result);
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bounded_deque_bag verification failed");
            $finish;
        end
    end

    // Offers one request, idling first while the sender is told to, and
    // returns at the edge where it was taken. The shadow deque is updated here
    // so the next request is chosen against the state the block will hold.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.apply_request(cmd, value);
    endtask

    // Searches look up a live entry half the time so that they hit; pushes
    // lean on the pool so that removal has duplicates to choose between.
    function automatic logic [FIELD_W-1:0] pick_value(input bit want_live);
        int r;
        r = $urandom_range(99);
        if (want_live && r < 50 && sb.occupancy() != 0)
            return sb.entry_at($urandom_range(sb.occupancy() - 1));
        if (r < 75)
            return VALUE_POOL[$urandom_range(7)];
        return $urandom();
    endfunction

    task automatic run_directed();
        // Refusals and misses on an empty deque, then the ignored codes.
        send_request(CMD_POP_FRONT, 32'h0000_0000);
        send_request(CMD_POP_BACK, 32'hFFFF_FFFF);
        send_request(CMD_CONTAINS, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0005);
        send_request(CMD_SPARE_LO, 32'h8000_0000);
        send_request(CMD_SPARE_HI, 32'h7FFF_FFFF);
        // Front pushes wrap the front index below slot zero right away.
        send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(CMD_PUSH_FRONT, 32'h8000_0000);
        send_request(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(CMD_PUSH_BACK, 32'h0000_0000);
        send_request(CMD_PUSH_BACK, 32'h8000_0000);
        send_request(CMD_CONTAINS, 32'hFFFF_FFFF);
        send_request(CMD_CONTAINS, 32'h1234_5678);
        send_request(CMD_SPARE_LO, 32'hFFFF_FFFF);
        // The duplicate at the front goes first, then a middle entry, then the
        // remaining duplicate now at the back, then a value that is absent.
        send_request(CMD_REMOVE, 32'h8000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h8000_0000);
        send_request(CMD_REMOVE, 32'hDEAD_BEEF);
        send_request(CMD_POP_BACK, 32'h0000_0000);
        send_request(CMD_POP_FRONT, 32'h0000_0000);
        send_request(CMD_POP_FRONT, 32'h0000_0000);
    endtask

    // Random traffic. Fill and drain modes run until the deque is full or empty
    // and then a few requests more, so that refusals follow; churn runs for a
    // random stretch. Ignored codes are sent now and then but not counted.
    task automatic run_traffic(input int n_requests);
        traffic_mode_t    mode;
        int               mode_left;
        int               sent;
        int               occ;
        int               push_pct;
        int               pop_pct;
        int               r;
        logic [CMD_W-1:0] cmd;
        mode      = CHURN;
        mode_left = 30;
        sent      = 0;
        while (sent < n_requests)
        begin
            occ = sb.occupancy();
            if (mode == CHURN || (mode == FILL_UP && occ == DEPTH)
                || (mode == EMPTY_OUT && occ == 0))
                mode_left--;
            if (mode_left <= 0)
            begin
                r         = $urandom_range(2);
                mode      = (r == 0) ? FILL_UP : (r == 1) ? EMPTY_OUT : CHURN;
                mode_left = (mode == CHURN) ? $urandom_range(20, 80) : 3;
            end
            case (mode)
                FILL_UP:
                begin
                    push_pct = 85;
                    pop_pct  = 5;
                end
                EMPTY_OUT:
                begin
                    push_pct = 5;
                    pop_pct  = 85;
                end
                default:
                begin
                    push_pct = 35;
                    pop_pct  = 30;
                end
            endcase
            r = $urandom_range(99);
            if (r < push_pct)
            begin
                cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                send_request(cmd, pick_value(1'b0));
                sent++;
            end
            else if (r < push_pct + pop_pct)
            begin
                cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                send_request(cmd, $urandom());
                sent++;
            end
            else if (r < 97)
            begin
                cmd = $urandom_range(1) ? CMD_REMOVE : CMD_CONTAINS;
                send_request(cmd, pick_value(1'b1));
                sent++;
            end
            else
            begin
                cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
                send_request(cmd, $urandom());
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(REQUESTS_A_PHASE);

        send_idle_pct  = 71;
        recv_stall_pct = 0;
        run_traffic(REQUESTS_A_PHASE);

        send_idle_pct  = 0;
        recv_stall_pct = 71;
        run_traffic(REQUESTS_A_PHASE);

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        run_traffic(REQUESTS_A_PHASE);

        // Wait for every owed result, then linger long enough that a stray
        // extra result would still be caught.
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("bounded_deque_bag verification clean");
        else
            $display("bounded_deque_bag verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bdb_pkg.sv
rtl/core/bdb_ctrl.sv
rtl/core/bdb_datapath.sv
rtl/core/bounded_deque_bag.sv
dv/bounded_deque_bag_sb_pkg.sv
dv/bounded_deque_bag_tb.sv
